FILE: design/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types and constants for the 3D Hooke's-law spring force block.
// ----------------------------------------------------------------------------
package sfh_pkg;

  // Coordinate and force width (signed fixed point)
  localparam int COORD_WIDTH = 32;
  // Configuration register width (unsigned fixed point)
  localparam int CFG_WIDTH = 31;
  // Number of spatial axes handled side by side
  localparam int NUM_AXES = 3;

  // Register port geometry
  localparam int DATA_WIDTH    = 32;
  localparam int ADDR_WIDTH    = 3;
  localparam int REG_IDX_WIDTH = ADDR_WIDTH - 2;

  // Register indexes
  localparam logic [REG_IDX_WIDTH-1:0] REG_REST_LENGTH = 1'b0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_STIFFNESS   = 1'b1;

  // Register reset values (1.0 in Q15.16)
  localparam logic [CFG_WIDTH-1:0] RESET_REST_LENGTH = CFG_WIDTH'(65536);
  localparam logic [CFG_WIDTH-1:0] RESET_STIFFNESS   = CFG_WIDTH'(65536);

  // Saturation limits of a force component
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Input word: the spring's two end points
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } sfh_in_t;

  // Result word: force on the start point
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] force_x;
    logic signed [COORD_WIDTH-1:0] force_y;
    logic signed [COORD_WIDTH-1:0] force_z;
    logic                          saturated;
  } sfh_out_t;

endpackage

FILE: design/sfh_regs.sv
// ----------------------------------------------------------------------------
// sfh_regs
// APB-style register file holding the rest length and the stiffness.
// ----------------------------------------------------------------------------
module sfh_regs
  import sfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output logic [CFG_WIDTH-1:0]  rest_length,
  output logic [CFG_WIDTH-1:0]  stiffness
);

  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_WIDTH-1:2];

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= RESET_REST_LENGTH;
      stiffness   <= RESET_STIFFNESS;
    end else if (wr_en) begin
      unique case (idx)
        REG_REST_LENGTH: rest_length <= pwdata[CFG_WIDTH-1:0];
        REG_STIFFNESS:   stiffness   <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_REST_LENGTH: prdata = DATA_WIDTH'(rest_length);
      REG_STIFFNESS:   prdata = DATA_WIDTH'(stiffness);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: design/sfh_sqrt.sv
// ----------------------------------------------------------------------------
// sfh_sqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module sfh_sqrt #(
  parameter int IW = 68,
  parameter int OW = 34,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          src_valid,
  input  logic [IW-1:0] radicand,
  input  logic [SW-1:0] src_side,
  output logic          res_valid,
  output logic [OW-1:0] root,
  output logic [SW-1:0] res_side
);

  logic [OW-1:0]    vld;
  logic [IW-1:0]    rem [OW];
  logic [OW-1:0]    rt  [OW];
  logic [SW-1:0]    sd  [OW];
  logic [IW+OW-1:0] nxt [OW];

  // Try the next root bit: keep it when its square increment fits the remainder
  function automatic logic [IW+OW-1:0] step(input logic [IW-1:0] r,
                                            input logic [OW-1:0] q,
                                            input int            b);
    logic [IW:0] trial;
    logic [IW:0] rx;
    trial = ((IW+1)'(q) << (b + 1)) | ((IW+1)'(1) << (2 * b));
    rx    = {1'b0, r};
    if (rx >= trial) begin
      return {IW'(rx - trial), q | (OW'(1) << b)};
    end
    return {r, q};
  endfunction

  // Per-stage trial subtraction
  always_comb begin
    nxt[0] = step(radicand, '0, OW - 1);
    for (int g = 1; g < OW; g++) begin
      nxt[g] = step(rem[g-1], rt[g-1], OW - 1 - g);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OW-2:0], src_valid};
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= src_side;
      for (int g = 0; g < OW; g++) begin
        rem[g] <= nxt[g][IW+OW-1:OW];
        rt[g]  <= nxt[g][OW-1:0];
      end
      for (int g = 1; g < OW; g++) begin
        sd[g] <= sd[g-1];
      end
    end
  end

  assign res_valid = vld[OW-1];
  assign root      = rt[OW-1];
  assign res_side  = sd[OW-1];

endmodule

FILE: design/sfh_div.sv
// ----------------------------------------------------------------------------
// sfh_div
// Pipelined restoring divider for all axes against one shared divisor: an
// overflow check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module sfh_div
  import sfh_pkg::*;
#(
  parameter int NW = 98,
  parameter int DW = 51,
  parameter int QW = 32,
  parameter int SW = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         src_valid,
  input  logic [NUM_AXES-1:0][NW-1:0]  num,
  input  logic [DW-1:0]                divisor,
  input  logic [SW-1:0]                src_side,
  output logic                         res_valid,
  output logic [NUM_AXES-1:0][QW-1:0]  quo,
  output logic [NUM_AXES-1:0]          ovf,
  output logic [SW-1:0]                res_side
);

  localparam int CMPW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW:0]                       vld;
  logic [DW-1:0]                     dvs  [QW+1];
  logic [SW-1:0]                     sd   [QW+1];
  logic [NUM_AXES-1:0]               of   [QW+1];
  logic [NUM_AXES-1:0][DW-1:0]       rem  [QW+1];
  logic [NUM_AXES-1:0][QW-1:0]       lo   [QW+1];
  logic [NUM_AXES-1:0][QW-1:0]       qt   [QW+1];
  logic [NUM_AXES-1:0][DW-1:0]       rem_next [1:QW];
  logic [NUM_AXES-1:0]               bit_next [1:QW];

  // Shift in one numerator bit and subtract where the divisor fits
  always_comb begin
    logic [DW:0] cand;
    logic        ge;
    for (int g = 1; g <= QW; g++) begin
      for (int l = 0; l < NUM_AXES; l++) begin
        cand            = {rem[g-1][l], lo[g-1][l][QW-1]};
        ge              = (cand >= {1'b0, dvs[g-1]});
        bit_next[g][l]  = ge;
        rem_next[g][l]  = ge ? DW'(cand - {1'b0, dvs[g-1]}) : cand[DW-1:0];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], src_valid};
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (en) begin
      // Entry: flag quotients that need more than QW bits
      dvs[0] <= divisor;
      sd[0]  <= src_side;
      for (int l = 0; l < NUM_AXES; l++) begin
        of[0][l]  <= (CMPW'(num[l]) >= (CMPW'(divisor) << QW));
        rem[0][l] <= DW'(num[l] >> QW);
        lo[0][l]  <= num[l][QW-1:0];
        qt[0][l]  <= '0;
      end
      for (int g = 1; g <= QW; g++) begin
        dvs[g] <= dvs[g-1];
        sd[g]  <= sd[g-1];
        of[g]  <= of[g-1];
        rem[g] <= rem_next[g];
        for (int l = 0; l < NUM_AXES; l++) begin
          lo[g][l] <= lo[g-1][l] << 1;
          qt[g][l] <= {qt[g-1][l][QW-2:0], bit_next[g][l]};
        end
      end
    end
  end

  assign res_valid = vld[QW];
  assign quo       = qt[QW];
  assign ovf       = of[QW];
  assign res_side  = sd[QW];

endmodule

FILE: design/spring_force_hooke_3d_top.sv
// ----------------------------------------------------------------------------
// spring_force_hooke_3d_top
// Hooke's-law spring force in 3D, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One spring word enters per clock while spring_ready is high, and its force
// word leaves through the output register. Most of the pipeline is the square
// root, which resolves one bit of the length per stage (COORD_WIDTH + 2
// stages), and the divider, which resolves one quotient bit per stage after
// an overflow check (COORD_WIDTH + 1 stages). Throughput is one word per
// cycle while spring_ready is high. The result sits in an output register
// backed by a one-word skid register, so input keeps flowing while a result
// waits; spring_ready drops only once the skid register is full. Registers:
// rest_length at byte 0x0, stiffness at 0x4, both unsigned Q15.16 in the low
// 31 bits, reset to 1.0. Write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module spring_force_hooke_3d_top
  import sfh_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  spring_valid,
  output logic                  spring_ready,
  input  sfh_in_t               spring_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output sfh_out_t              result_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;                    // difference magnitude
  localparam int SUMW = 2 * MW + 2;                // sum of squares
  localparam int LW   = SUMW / 2;                  // length
  localparam int EMW  = (LW > CFG_WIDTH) ? LW : CFG_WIDTH;
  localparam int DKW  = MW + CFG_WIDTH;            // |d| * k
  localparam int DKL  = DKW / 2;
  localparam int DKH  = DKW - DKL;
  localparam int NW   = DKW + EMW;                 // full numerator
  localparam int DVW  = LW + FRAC_BITS + 1;        // length << (FRAC_BITS+1)
  localparam int SQSW = NUM_AXES * DKW + NUM_AXES;
  localparam int DVSW = NUM_AXES + 1;

  logic [CFG_WIDTH-1:0] rest_length;
  logic [CFG_WIDTH-1:0] stiffness;
  logic                 en;

  sfh_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rest_length (rest_length),
    .stiffness   (stiffness)
  );

  // The whole pipeline moves while the skid register is free
  logic skid_vld;
  assign en           = ~skid_vld;
  assign spring_ready = en;

  // Stage A: difference vector end - start
  logic [NUM_AXES-1:0][CW-1:0] pt_a;
  logic [NUM_AXES-1:0][CW-1:0] pt_b;
  logic                        a_vld;
  logic [NUM_AXES-1:0][MW-1:0] a_dif;

  assign pt_a = {spring_data.start_z, spring_data.start_y, spring_data.start_x};
  assign pt_b = {spring_data.end_z, spring_data.end_y, spring_data.end_x};

  // Stage B: magnitude and sign
  logic                        b_vld;
  logic [NUM_AXES-1:0][MW-1:0] b_mag;
  logic [NUM_AXES-1:0]         b_sgn;

  // Stage C: squares and |d| * k
  logic                          c_vld;
  logic [NUM_AXES-1:0][2*MW-1:0] c_sq;
  logic [NUM_AXES-1:0][DKW-1:0]  c_dk;
  logic [NUM_AXES-1:0]           c_sgn;

  // Stage D: sum of squares
  logic                         d_vld;
  logic [SUMW-1:0]              d_sum;
  logic [NUM_AXES-1:0][DKW-1:0] d_dk;
  logic [NUM_AXES-1:0]          d_sgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else if (en) begin
      a_vld <= spring_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_AXES; l++) begin
        a_dif[l] <= {pt_b[l][CW-1], pt_b[l]} - {pt_a[l][CW-1], pt_a[l]};
        b_sgn[l] <= a_dif[l][MW-1];
        b_mag[l] <= a_dif[l][MW-1] ? (~a_dif[l] + 1'b1) : a_dif[l];
        c_sq[l]  <= b_mag[l] * b_mag[l];
        c_dk[l]  <= b_mag[l] * stiffness;
      end
      c_sgn <= b_sgn;
      d_sum <= SUMW'(c_sq[0]) + SUMW'(c_sq[1]) + SUMW'(c_sq[2]);
      d_dk  <= c_dk;
      d_sgn <= c_sgn;
    end
  end

  // Length of the difference vector
  logic                         r_vld;
  logic [LW-1:0]                r_len;
  logic [SQSW-1:0]              r_side;
  logic [NUM_AXES-1:0][DKW-1:0] r_dk;
  logic [NUM_AXES-1:0]          r_sgn;

  sfh_sqrt #(
    .IW (SUMW),
    .OW (LW),
    .SW (SQSW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (d_vld),
    .radicand  (d_sum),
    .src_side  ({d_dk, d_sgn}),
    .res_valid (r_vld),
    .root      (r_len),
    .res_side  (r_side)
  );

  assign {r_dk, r_sgn} = r_side;

  // Stage E: extension magnitude and sign
  logic                         e_vld;
  logic [LW-1:0]                e_len;
  logic [EMW-1:0]               e_emag;
  logic                         e_neg_ext;
  logic                         e_zero;
  logic [NUM_AXES-1:0][DKW-1:0] e_dk;
  logic [NUM_AXES-1:0]          e_sgn;

  // Stage F: partial products of |d| * k * |L - rest|
  logic                             f_vld;
  logic [LW-1:0]                    f_len;
  logic                             f_zero;
  logic [NUM_AXES-1:0]              f_neg;
  logic [NUM_AXES-1:0][DKL+EMW-1:0] f_pl;
  logic [NUM_AXES-1:0][DKH+EMW-1:0] f_ph;

  // Stage G: numerator and divisor
  logic                        g_vld;
  logic [NUM_AXES-1:0][NW-1:0] g_num;
  logic [DVW-1:0]              g_div;
  logic                        g_zero;
  logic [NUM_AXES-1:0]         g_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      e_vld <= r_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_len     <= r_len;
      e_zero    <= (r_len == '0);
      e_neg_ext <= (EMW'(r_len) < EMW'(rest_length));
      e_emag    <= (EMW'(r_len) < EMW'(rest_length)) ?
                   EMW'(rest_length) - EMW'(r_len) : EMW'(r_len) - EMW'(rest_length);
      e_dk      <= r_dk;
      e_sgn     <= r_sgn;

      f_len  <= e_len;
      f_zero <= e_zero;
      for (int l = 0; l < NUM_AXES; l++) begin
        f_neg[l] <= e_sgn[l] ^ e_neg_ext;
        f_pl[l]  <= e_dk[l][DKL-1:0] * e_emag;
        f_ph[l]  <= e_dk[l][DKW-1:DKL] * e_emag;
        g_num[l] <= NW'(f_pl[l]) + (NW'(f_ph[l]) << DKL);
      end

      g_div  <= {f_len, {(FRAC_BITS+1){1'b0}}};
      g_zero <= f_zero;
      g_neg  <= f_neg;
    end
  end

  // Quotient per axis
  logic                        q_vld;
  logic [NUM_AXES-1:0][CW-1:0] q_quo;
  logic [NUM_AXES-1:0]         q_ovf;
  logic [DVSW-1:0]             q_side;
  logic                        q_zero;
  logic [NUM_AXES-1:0]         q_neg;

  sfh_div #(
    .NW (NW),
    .DW (DVW),
    .QW (CW),
    .SW (DVSW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (g_vld),
    .num       (g_num),
    .divisor   (g_div),
    .src_side  ({g_zero, g_neg}),
    .res_valid (q_vld),
    .quo       (q_quo),
    .ovf       (q_ovf),
    .res_side  (q_side)
  );

  assign {q_zero, q_neg} = q_side;

  // Stage H: sign, clamp and zero-length override
  logic                        h_vld;
  sfh_out_t                    h_data;
  sfh_out_t                    h_next;
  logic [NUM_AXES-1:0][CW-1:0] fval;
  logic [NUM_AXES-1:0]         clamp;

  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      if (q_zero) begin
        clamp[l] = 1'b0;
        fval[l]  = '0;
      end else if (q_neg[l]) begin
        clamp[l] = q_ovf[l] | (q_quo[l][CW-1] & (|q_quo[l][CW-2:0]));
        fval[l]  = clamp[l] ? COORD_MIN : (~q_quo[l] + 1'b1);
      end else begin
        clamp[l] = q_ovf[l] | q_quo[l][CW-1];
        fval[l]  = clamp[l] ? COORD_MAX : q_quo[l];
      end
    end
    h_next.force_x   = fval[0];
    h_next.force_y   = fval[1];
    h_next.force_z   = fval[2];
    h_next.saturated = |clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_data <= h_next;
    end
  end

  // Output register with skid: drain the skid first, else take stage H
  sfh_out_t skid_data;
  logic     take;

  assign take = result_valid & result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_vld     <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (h_vld) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        result_data <= skid_data;
      end
    end else if (h_vld) begin
      if (!result_valid || take) begin
        result_data <= h_data;
      end else begin
        skid_data <= h_data;
      end
    end
  end

endmodule

FILE: verif/tb_spring_force_hooke_3d_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spring_force_hooke_3d_top
// Self-checking bench for the 3D Hooke's-law spring force block. Spring words
// go in through a valid/ready channel with random gaps, and results come back
// under random back-pressure. Each accepted word is scored against a bench-side
// force calculation that tracks rest length and stiffness across several
// register settings written over the APB-style port.
// ----------------------------------------------------------------------------
module tb_spring_force_hooke_3d_top;
  import sfh_pkg::*;

  localparam int  FRAC = 16;
  localparam int  PIPE_DELAY = 2 * COORD_WIDTH + 12;
  localparam int  HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 600000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  spring_valid = 1'b0;
  logic                  spring_ready;
  sfh_in_t               spring_data = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  sfh_out_t              result_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  // bench copy of the spring registers
  logic [CFG_WIDTH-1:0] rest_len_q = RESET_REST_LENGTH;
  logic [CFG_WIDTH-1:0] stiff_q    = RESET_STIFFNESS;

  sfh_out_t force_queue[$];
  int       fail_count = 0;
  int       force_count = 0;
  int       sat_count = 0;
  longint   cycle_count = 0;
  bit       hold_req = 1'b0;
  bit       no_idle = 1'b0;

  spring_force_hooke_3d_top #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .spring_valid(spring_valid), .spring_ready(spring_ready), .spring_data(spring_data),
    .result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout waiting for the block", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // exact force on the start point for one spring word
  function automatic sfh_out_t calc_spring_force(sfh_in_t s);
    logic signed [33:0] dv[3];
    logic [32:0]        dm[3];
    logic [127:0]       sq, len, trial, divisor, prod, q;
    logic signed [35:0] ext;
    logic [35:0]        emag;
    logic [31:0]        fc[3];
    logic               neg, sat;
    sfh_out_t           r;
    dv[0] = $signed({{2{s.end_x[31]}}, s.end_x}) - $signed({{2{s.start_x[31]}}, s.start_x});
    dv[1] = $signed({{2{s.end_y[31]}}, s.end_y}) - $signed({{2{s.start_y[31]}}, s.start_y});
    dv[2] = $signed({{2{s.end_z[31]}}, s.end_z}) - $signed({{2{s.start_z[31]}}, s.start_z});
    sq = '0;
    for (int a = 0; a < 3; a++) begin
      dm[a] = dv[a] < 0 ? 33'(-dv[a]) : 33'(dv[a]);
      sq = sq + 128'(dm[a]) * 128'(dm[a]);
    end
    r = '0;
    if (sq == 0) return r;
    // integer square root, one bit at a time
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = len | (128'(1) << b);
      if (trial * trial <= sq) len = trial;
    end
    ext = $signed({1'b0, len[34:0]}) - $signed({5'b0, rest_len_q});
    emag = ext < 0 ? 36'(-ext) : 36'(ext);
    divisor = len << (FRAC + 1);
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      prod = 128'(dm[a]) * 128'(stiff_q) * 128'(emag);
      q = prod / divisor;
      neg = (dv[a] < 0) != (ext < 0);
      if (neg) begin
        if (q > 128'(COORD_MIN)) begin
          q = 128'(COORD_MIN);
          sat = 1'b1;
        end
        fc[a] = -q[31:0];
      end else begin
        if (q > 128'(COORD_MAX)) begin
          q = 128'(COORD_MAX);
          sat = 1'b1;
        end
        fc[a] = q[31:0];
      end
    end
    r.force_x = fc[0];
    r.force_y = fc[1];
    r.force_z = fc[2];
    r.saturated = sat;
    return r;
  endfunction

  // offer one spring word, hold it until taken, then maybe idle
  task automatic send_spring(sfh_in_t s);
    int gap;
    spring_data  <= s;
    spring_valid <= 1'b1;
    do @(posedge clk); while (!spring_ready);
    force_queue.push_back(calc_spring_force(s));
    gap = pick_gap();
    if (gap > 0) begin
      spring_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // setup then access phase; the register takes the value at the access edge
  task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_REST_LENGTH) rest_len_q = val[CFG_WIDTH-1:0];
    else stiff_q = val[CFG_WIDTH-1:0];
    // return to idle between transfers
    @(posedge clk);
  endtask

  // let every outstanding word drain before touching registers
  task automatic drain();
    spring_valid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY + 10) @(posedge clk);
  endtask

  function automatic sfh_in_t make_spring(int mode);
    sfh_in_t s;
    logic signed [31:0] base;
    s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode == 0) begin
      // a few units apart, near a random point
      base = $urandom_range(32'h0100_0000) - 32'h0080_0000;
      s.start_x = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      s.start_y = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      s.start_z = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      s.end_x   = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      s.end_y   = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      s.end_z   = base + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    end else if (mode == 1) begin
      // coincident points
      s.end_x = s.start_x;
      s.end_y = s.start_y;
      s.end_z = s.start_z;
    end
    return s;
  endfunction

  task automatic run_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      send_spring(make_spring(r < 60 ? 0 : (r < 63 ? 1 : 2)));
    end
  endtask

  task automatic test_directed();
    sfh_in_t s;
    s = '0;
    send_spring(s);                                   // zero length
    s.end_x = 32'sh0001_0000; send_spring(s);         // exactly at rest
    s.end_x = 32'sh0000_8000; send_spring(s);         // compressed
    s.end_x = 32'sh0003_0000; send_spring(s);         // stretched
    s = '0; s.end_y = -32'sh0002_0000; send_spring(s);
    s = '0; s.end_z = 32'sh0000_0001; send_spring(s); // shortest spring
    s = {{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}; send_spring(s);
    s = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}}; send_spring(s);
    s = {32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0}; send_spring(s);
    s = {32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000};
    send_spring(s);
    s = {6{32'h5555_AAAA}}; send_spring(s);           // coincident, busy bits
    s = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'h0004_0000, 32'h0006_0000, 32'h0003_0000}; send_spring(s);
    s = {32'h0, 32'h0, 32'h0, 32'h0000_3000, 32'h0000_4000, 32'h0}; send_spring(s);
  endtask

  task automatic test_register_sweep();
    logic [DATA_WIDTH-1:0] rests[5];
    logic [DATA_WIDTH-1:0] stiffs[5];
    rests  = '{32'h0, 32'h7FFF_FFFF, 32'h0002_0000, $urandom, 32'h0001_0000};
    stiffs = '{32'h7FFF_FFFF, 32'h0, $urandom, 32'h0000_0001, 32'h0001_0000};
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(REG_REST_LENGTH, rests[p]);
      write_reg(REG_STIFFNESS, stiffs[p]);
      test_directed();
      run_random(260);
    end
  endtask

  task automatic test_backpressure();
    drain();
    write_reg(REG_STIFFNESS, 32'h0000_4000);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    run_random(250);
    no_idle = 1'b0;
    run_random(200);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // score each taken result against the oldest expectation
  always @(posedge clk) begin
    sfh_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (force_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_data);
        fail_count++;
      end else begin
        want = force_queue.pop_front();
        force_count++;
        if (want.saturated) sat_count++;
        if (result_data.force_x !== want.force_x)
          $display("%0t: force_x expected %h got %h", $time, want.force_x, result_data.force_x);
        if (result_data.force_y !== want.force_y)
          $display("%0t: force_y expected %h got %h", $time, want.force_y, result_data.force_y);
        if (result_data.force_z !== want.force_z)
          $display("%0t: force_z expected %h got %h", $time, want.force_z, result_data.force_z);
        if (result_data.saturated !== want.saturated)
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   result_data.saturated);
        if (result_data !== want) fail_count++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random(200);
    test_register_sweep();
    test_backpressure();
    drain();
    if (force_queue.size() != 0) fail_count++;
    $display("Checked %0d force words (%0d saturated) over seven register settings,",
             force_count, sat_count);
    $display("including one long output hold-off with the input kept busy.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
